### rtl/wvc_pkg.sv
`timescale 1ns / 1ps
// wvc_pkg: shared types and constants of the waypoint velocity controller
// no dependencies; read by wvc_out_if, wvc_cfg_if, wvc_cordic and the top level

package wvc_pkg;

	// result mode codes
	typedef enum logic [2:0] {
		MODE_TURN   = 3'd0,
		MODE_CRUISE = 3'd1,
		MODE_ALIGN  = 3'd2,
		MODE_HOLD   = 3'd3,
		MODE_PASSED = 3'd4
	} mode_t;

	// configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_ANGLE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REACH_ANGLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REACH_DIST  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_GAIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_LIMIT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 3'd6;

	// register reset values
	localparam logic [13:0] TURN_ANGLE_RST  = 14'd3217;
	localparam logic [13:0] REACH_ANGLE_RST = 14'd804;
	localparam logic [15:0] REACH_DIST_RST  = 16'd512;
	localparam logic [11:0] ROT_GAIN_RST    = 12'd768;
	localparam logic [11:0] SPEED_GAIN_RST  = 12'd256;
	localparam logic [14:0] ROT_LIMIT_RST   = 15'd4096;
	localparam logic [14:0] SPEED_LIMIT_RST = 15'd8192;

	// cordic angle table, atan(2^-i) in Q.16
	localparam int ATAN_N = 16;
	localparam int ATAN_TAB [ATAN_N] = '{
		51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2
	};
	localparam int HALF_PI_Q16 = 102944;
	localparam int PI_Q12      = 12868;

endpackage

### rtl/wvc_in_if.sv
`timescale 1ns / 1ps
// wvc_in_if: target offset channel, valid/ready plus the target fields
// depends on nothing

interface wvc_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] offset_x;
	logic signed [15:0] offset_y;
	logic signed [14:0] heading_error;
	logic               final_waypoint;

	modport source (output valid, offset_x, offset_y, heading_error, final_waypoint,
		input ready);
	modport sink (input valid, offset_x, offset_y, heading_error, final_waypoint,
		output ready);
endinterface

### rtl/wvc_out_if.sv
`timescale 1ns / 1ps
// wvc_out_if: velocity command channel, valid/ready plus the command fields
// depends on wvc_pkg for the mode type

interface wvc_out_if;
	logic               valid;
	logic               ready;
	logic [14:0]        linear_speed;
	logic signed [15:0] rotation_rate;
	wvc_pkg::mode_t     mode;
	logic               speed_clamped;
	logic               rate_clamped;
	logic               keep_target;

	modport source (output valid, linear_speed, rotation_rate, mode, speed_clamped,
		rate_clamped, keep_target, input ready);
	modport sink (input valid, linear_speed, rotation_rate, mode, speed_clamped,
		rate_clamped, keep_target, output ready);
endinterface

### rtl/wvc_cfg_if.sv
`timescale 1ns / 1ps
// wvc_cfg_if: register write channel, valid/ready plus index and data
// depends on wvc_pkg for the port widths

interface wvc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [wvc_pkg::CFG_IDX_W-1:0]    index;
	logic [wvc_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/wvc_cordic.sv
`timescale 1ns / 1ps
// wvc_cordic: pipelined atan2 by cordic vectoring, one stage per iteration
// depends on wvc_pkg for the angle table

module wvc_cordic (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] x,
	input  logic signed [15:0] y,
	output logic signed [14:0] bearing
);
	localparam int XW = 33;
	localparam int ZW = 20;
	localparam int N  = wvc_pkg::ATAN_N;

	logic signed [XW-1:0] x_s [0:N];
	logic signed [XW-1:0] y_s [0:N];
	logic signed [ZW-1:0] z_s [0:N];
	logic signed [XW-1:0] xe, ye;
	logic signed [ZW-1:0] zr;
	logic signed [14:0]   bear_s;

	assign xe = XW'(x) <<< 14;
	assign ye = XW'(y) <<< 14;

	// left half plane is turned by a quarter first
	always_ff @(posedge clk) begin
		if (en) begin
			if (xe < 0) begin
				if (ye >= 0) begin
					x_s[0] <= ye;
					y_s[0] <= -xe;
					z_s[0] <= ZW'(wvc_pkg::HALF_PI_Q16);
				end else begin
					x_s[0] <= -ye;
					y_s[0] <= xe;
					z_s[0] <= -ZW'(wvc_pkg::HALF_PI_Q16);
				end
			end else begin
				x_s[0] <= xe;
				y_s[0] <= ye;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		logic signed [XW-1:0] xsh, ysh;
		assign xsh = x_s[i] >>> i;
		assign ysh = y_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + ysh;
					y_s[i+1] <= y_s[i] - xsh;
					z_s[i+1] <= z_s[i] + ZW'(wvc_pkg::ATAN_TAB[i]);
				end else begin
					x_s[i+1] <= x_s[i] - ysh;
					y_s[i+1] <= y_s[i] + xsh;
					z_s[i+1] <= z_s[i] - ZW'(wvc_pkg::ATAN_TAB[i]);
				end
			end
		end
	end

	// round q.16 to q3.12 and saturate to +-pi
	assign zr = (z_s[N] + ZW'(8)) >>> 4;

	always_ff @(posedge clk) begin
		if (en) begin
			if (zr > ZW'(wvc_pkg::PI_Q12)) begin
				bear_s <= 15'(wvc_pkg::PI_Q12);
			end else if (zr < -ZW'(wvc_pkg::PI_Q12)) begin
				bear_s <= -15'(wvc_pkg::PI_Q12);
			end else begin
				bear_s <= 15'(zr);
			end
		end
	end

	assign bearing = bear_s;
endmodule

### rtl/wvc_div.sv
`timescale 1ns / 1ps
// wvc_div: pipelined restoring unsigned divider, one quotient bit per stage
// no dependencies; sat flags a quotient of 2^QW or more

module wvc_div #(
	parameter int NW = 43,
	parameter int DW = 32,
	parameter int QW = 26
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo,
	output logic          sat
);
	localparam int W = ((NW > DW + QW) ? NW : DW + QW) + 1;

	logic [W-1:0]  rem_s [0:QW];
	logic [DW-1:0] den_s [0:QW];
	logic [QW-1:0] q_s   [0:QW];
	logic          sat_s [0:QW];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= W'(num);
			den_s[0] <= den;
			q_s[0]   <= '0;
			sat_s[0] <= W'(num) >= (W'(den) << QW);
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_bit
		logic [W-1:0] dsh;
		assign dsh = W'(den_s[j]) << (QW - 1 - j);
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j+1] <= den_s[j];
				sat_s[j+1] <= sat_s[j];
				if (rem_s[j] >= dsh) begin
					rem_s[j+1] <= rem_s[j] - dsh;
					q_s[j+1]   <= q_s[j] | (QW'(1) << (QW - 1 - j));
				end else begin
					rem_s[j+1] <= rem_s[j];
					q_s[j+1]   <= q_s[j];
				end
			end
		end
	end

	assign quo = q_s[QW];
	assign sat = sat_s[QW];
endmodule

### rtl/waypoint_velocity_controller.sv
`timescale 1ns / 1ps
// waypoint_velocity_controller: pure-pursuit velocity command from a target offset
// depends on wvc_pkg, wvc_in_if, wvc_out_if, wvc_cfg_if, wvc_cordic, wvc_div

// Takes one target transfer per clock unless a command is held at the output, and returns
// one command per target, in order. Every stage moves together: when a command waits
// at the output and is not taken, the whole pipeline holds and target ready drops in the
// same cycle. The depth is set by the longest chain, the distance square root (18 stages)
// and then the arc-rate divider (27 stages: input and one per quotient bit); the bearing
// cordic and the speed-rescale divider run beside it. Registers are written through the
// cfg channel, which is always ready; write them only while no target is in flight.

module waypoint_velocity_controller (
	input  logic         clk,
	input  logic         arst_n,
	wvc_in_if.sink       target,
	wvc_out_if.source    command,
	wvc_cfg_if.sink      cfg
);
	// stage plan, a number is the pipeline register holding the value
	localparam int CORDIC_LAT = wvc_pkg::ATAN_N + 2;
	localparam int RT_N       = 18;          // root bits of sqrt(16 * sq)
	localparam int DIV1_QW    = 26;          // arc rate quotient bits
	localparam int DIV2_QW    = 15;          // rescaled speed quotient bits
	localparam int S_SQ       = 2;
	localparam int S_TURN     = 1 + CORDIC_LAT + 1;
	localparam int S_GAIN     = S_TURN + 1;  // sqrt root lands at S_SQ + RT_N
	localparam int S_CLAMP    = S_GAIN + 1;
	localparam int S_TAY      = S_CLAMP + 1;
	localparam int S_NUM      = S_TAY + 1;
	localparam int S_END      = S_NUM + DIV1_QW + 1;
	localparam int S_NN       = S_END - DIV2_QW - 1;
	localparam int S_RLSQ     = S_NN - 1;
	localparam int NS         = S_END + 1;

	// per-item fields carried down the pipe
	typedef struct packed {
		logic signed [14:0] he;
		logic               fin;
		logic               yneg;
		logic [15:0]        ay;
		logic [31:0]        sq;
		logic               far;
		logic               turn;
		logic signed [14:0] ang;
		logic signed [27:0] gp;
		logic [29:0]        prod;
		logic signed [15:0] rva;
		logic               rca;
		logic [14:0]        t;
		logic               sc;
		logic [30:0]        tay;
		logic [42:0]        num;
		logic [46:0]        rlsq;
		logic [47:0]        nn;
	} side_t;

	// configuration registers
	logic [13:0] tia_q;
	logic [13:0] hra_q;
	logic [31:0] rd_sq_q;
	logic [11:0] rg_q;
	logic [11:0] sg_q;
	logic [14:0] rl_q;
	logic [14:0] sl_q;

	logic              adv;
	logic [NS:1]       vld_s;
	side_t             side_in;
	side_t             side_s [1:S_END];
	logic signed [15:0] x_s1, y_s1;
	logic [31:0]       x2_s1, y2_s1;
	logic signed [31:0] xx, yy;
	logic signed [14:0] bearing;

	// output register
	logic [14:0]        ls_s52;
	logic signed [15:0] rv_s52;
	wvc_pkg::mode_t     md_s52;
	logic               sc_s52, rc_s52, kp_s52;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tia_q   <= wvc_pkg::TURN_ANGLE_RST;
			hra_q   <= wvc_pkg::REACH_ANGLE_RST;
			rd_sq_q <= 32'(wvc_pkg::REACH_DIST_RST) * 32'(wvc_pkg::REACH_DIST_RST);
			rg_q    <= wvc_pkg::ROT_GAIN_RST;
			sg_q    <= wvc_pkg::SPEED_GAIN_RST;
			rl_q    <= wvc_pkg::ROT_LIMIT_RST;
			sl_q    <= wvc_pkg::SPEED_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				wvc_pkg::CFG_TURN_ANGLE:  tia_q <= cfg.data[13:0];
				wvc_pkg::CFG_REACH_ANGLE: hra_q <= cfg.data[13:0];
				wvc_pkg::CFG_REACH_DIST: begin
					// squared once here so the far test is a plain compare
					rd_sq_q <= 32'(cfg.data) * 32'(cfg.data);
				end
				wvc_pkg::CFG_ROT_GAIN:    rg_q <= cfg.data[11:0];
				wvc_pkg::CFG_SPEED_GAIN:  sg_q <= cfg.data[11:0];
				wvc_pkg::CFG_ROT_LIMIT:   rl_q <= cfg.data[14:0];
				wvc_pkg::CFG_SPEED_LIMIT: sl_q <= cfg.data[14:0];
				default: ;
			endcase
		end
	end

	// global advance: the pipe moves unless a finished command is held
	assign adv          = !vld_s[NS] || command.ready;
	assign target.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NS-1:1], target.valid};
		end
	end

	// stage 1: capture and square the offsets
	assign xx = target.offset_x * target.offset_x;
	assign yy = target.offset_y * target.offset_y;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1  <= target.offset_x;
			y_s1  <= target.offset_y;
			x2_s1 <= $unsigned(xx);
			y2_s1 <= $unsigned(yy);
		end
	end

	always_comb begin
		side_in      = '0;
		side_in.he   = target.heading_error;
		side_in.fin  = target.final_waypoint;
		side_in.yneg = target.offset_y[15];
		side_in.ay   = target.offset_y[15] ? 16'(-target.offset_y) : 16'(target.offset_y);
	end

	// bearing, available at stage S_TURN - 1
	wvc_cordic u_cordic (
		.clk     (clk),
		.en      (adv),
		.x       (x_s1),
		.y       (y_s1),
		.bearing (bearing)
	);

	// distance: digit-by-digit square root of 16 * sq, two radicand bits a stage
	logic [35:0] rt_v    [1:RT_N];
	logic [21:0] rt_rem  [1:RT_N];
	logic [17:0] rt_root [1:RT_N];

	for (genvar j = 0; j < RT_N; j++) begin : g_root
		logic [35:0] pv;
		logic [21:0] prem, rem2, trial;
		logic [17:0] proot;
		if (j == 0) begin : g_first
			assign pv    = {side_s[S_SQ].sq, 4'b0000};
			assign prem  = '0;
			assign proot = '0;
		end else begin : g_next
			assign pv    = rt_v[j];
			assign prem  = rt_rem[j];
			assign proot = rt_root[j];
		end
		assign rem2  = {prem[19:0], pv[35-2*j -: 2]};
		assign trial = {2'b00, proot, 2'b01};
		always_ff @(posedge clk) begin
			if (adv) begin
				rt_v[j+1] <= pv;
				if (rem2 >= trial) begin
					rt_rem[j+1]  <= rem2 - trial;
					rt_root[j+1] <= {proot[16:0], 1'b1};
				end else begin
					rt_rem[j+1]  <= rem2;
					rt_root[j+1] <= {proot[16:0], 1'b0};
				end
			end
		end
	end

	// stage-specific arithmetic
	logic [31:0]        sq_sum;
	logic [14:0]        bear_abs;
	logic signed [27:0] rvr, rlim;
	logic [21:0]        tt;
	side_t              sg21;

	assign sq_sum   = x2_s1 + y2_s1;
	assign bear_abs = bearing[14] ? 15'(-bearing) : 15'(bearing);
	assign sg21     = side_s[S_GAIN];
	assign rvr      = sg21.gp >>> 8;
	assign rlim     = 28'($signed({1'b0, rl_q}));
	assign tt       = 22'((sg21.prod + 30'd128) >> 8);

	for (genvar k = 1; k <= S_END; k++) begin : g_side
		side_t prev, nxt;
		if (k == 1) begin : g_first
			assign prev = side_in;
		end else begin : g_next
			assign prev = side_s[k-1];
		end
		always_comb begin
			nxt = prev;
			if (k == S_SQ) begin
				nxt.sq  = sq_sum;
				nxt.far = sq_sum > rd_sq_q;
			end
			if (k == S_TURN) begin
				// turn in place toward a far target at a large bearing
				nxt.turn = prev.far && (bear_abs > {1'b0, tia_q});
				nxt.ang  = nxt.turn ? bearing : prev.he;
			end
			if (k == S_GAIN) begin
				nxt.gp   = 28'($signed({1'b0, rg_q})) * 28'(prev.ang) + 28'sd128;
				nxt.prod = 30'(rt_root[RT_N]) * 30'(sg_q);
			end
			if (k == S_CLAMP) begin
				nxt.rca = (rvr > rlim) || (rvr < -rlim);
				if (rvr > rlim) begin
					nxt.rva = 16'(rlim);
				end else if (rvr < -rlim) begin
					nxt.rva = 16'(-rlim);
				end else begin
					nxt.rva = 16'(rvr);
				end
				nxt.sc = tt > 22'(sl_q);
				nxt.t  = nxt.sc ? sl_q : 15'(tt);
			end
			if (k == S_TAY) begin
				nxt.tay = 31'(prev.t) * 31'(prev.ay);
			end
			if (k == S_NUM) begin
				nxt.num = 43'({prev.tay, 11'b0}) + 43'(prev.sq >> 1);
			end
			if (k == S_RLSQ) begin
				nxt.rlsq = 47'(rl_q) * 47'(prev.sq);
			end
			if (k == S_NN) begin
				nxt.nn = 48'(prev.rlsq) + 48'({prev.ay, 10'b0});
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= nxt;
			end
		end
	end

	// arc rate magnitude: (t*|y|*2048 + sq/2) / sq
	logic [DIV1_QW-1:0] mag;
	logic               mag_sat;

	wvc_div #(
		.NW (43),
		.DW (32),
		.QW (DIV1_QW)
	) u_div_rate (
		.clk (clk),
		.en  (adv),
		.num (side_s[S_NUM].num),
		.den (side_s[S_NUM].sq),
		.quo (mag),
		.sat (mag_sat)
	);

	// rescaled speed: (limit*sq + 1024*|y|) / (2048*|y|), only its minimum with t counts
	logic [DIV2_QW-1:0] nt;
	logic               nt_sat;

	wvc_div #(
		.NW (48),
		.DW (27),
		.QW (DIV2_QW)
	) u_div_speed (
		.clk (clk),
		.en  (adv),
		.num (side_s[S_NN].nn),
		.den ({side_s[S_NN].ay, 11'b0}),
		.quo (nt),
		.sat (nt_sat)
	);

	// last stage: pick the mode and assemble the command
	logic [14:0]        ls_c;
	logic signed [15:0] rv_c;
	wvc_pkg::mode_t     md_c;
	logic               sc_c, rc_c, kp_c;

	always_comb begin
		side_t       fs;
		logic [14:0] he_abs;
		logic        mag_big;
		logic [14:0] mag_lim;
		logic [14:0] t_new;
		fs      = side_s[S_END];
		he_abs  = fs.he[14] ? 15'(-fs.he) : 15'(fs.he);
		mag_big = mag_sat || (mag > DIV1_QW'(rl_q));
		mag_lim = mag_big ? rl_q : mag[14:0];
		t_new   = (!nt_sat && (nt < fs.t)) ? nt : fs.t;
		ls_c    = '0;
		rv_c    = '0;
		md_c    = wvc_pkg::MODE_PASSED;
		sc_c    = 1'b0;
		rc_c    = 1'b0;
		kp_c    = 1'b1;
		if (fs.turn) begin
			md_c = wvc_pkg::MODE_TURN;
			rv_c = fs.rva;
			rc_c = fs.rca;
		end else if (fs.far) begin
			// arc follow; a clamped rate pulls the speed down to keep the arc
			md_c = wvc_pkg::MODE_CRUISE;
			sc_c = fs.sc;
			rc_c = mag_big;
			ls_c = mag_big ? t_new : fs.t;
			rv_c = fs.yneg ? -$signed(16'(mag_lim)) : $signed(16'(mag_lim));
		end else if (fs.fin) begin
			if (he_abs > {1'b0, hra_q}) begin
				md_c = wvc_pkg::MODE_ALIGN;
				rv_c = fs.rva;
				rc_c = fs.rca;
			end else begin
				md_c = wvc_pkg::MODE_HOLD;
			end
		end else begin
			kp_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ls_s52 <= ls_c;
			rv_s52 <= rv_c;
			md_s52 <= md_c;
			sc_s52 <= sc_c;
			rc_s52 <= rc_c;
			kp_s52 <= kp_c;
		end
	end

	assign command.valid         = vld_s[NS];
	assign command.linear_speed  = ls_s52;
	assign command.rotation_rate = rv_s52;
	assign command.mode          = md_s52;
	assign command.speed_clamped = sc_s52;
	assign command.rate_clamped  = rc_s52;
	assign command.keep_target   = kp_s52;
endmodule
